// File: hw/rtl/yuv_fade_yuv_pixel_macros.svh
// ----------------------------------------------------------------------------
// yuv_fade_yuv_pixel_macros
// Assertion macros for the pixel fade pipeline.
// ----------------------------------------------------------------------------
`ifndef YUV_FADE_YUV_PIXEL_MACROS_SVH
`define YUV_FADE_YUV_PIXEL_MACROS_SVH

// same-cycle implication
`define YFY_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("yfy assertion failed");

// next-cycle implication
`define YFY_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("yfy assertion failed");

`endif

// File: hw/rtl/yfy_pkg.sv
// ----------------------------------------------------------------------------
// yfy_pkg
// Shared constants, types and coefficient helper for the pixel fade pipeline.
// ----------------------------------------------------------------------------
package yfy_pkg;

   localparam int COEF_FRAC_BITS_DEF = 16;
   localparam int PIX_W              = 8;
   localparam int STAGES             = 6;

   localparam logic [PIX_W-1:0] FADE_RESET = 8'd255;

   // coefficients in millionths
   localparam longint M_Y_RGB = 1164383;
   localparam longint M_V_R   = 1596027;
   localparam longint M_U_G   = 391762;
   localparam longint M_V_G   = 812968;
   localparam longint M_U_B   = 2017232;
   localparam longint M_R_Y   = 256788;
   localparam longint M_G_Y   = 504129;
   localparam longint M_B_Y   = 97906;
   localparam longint M_R_U   = 148223;
   localparam longint M_G_U   = 290993;
   localparam longint M_B_U   = 439216;
   localparam longint M_R_V   = 439216;
   localparam longint M_G_V   = 367788;
   localparam longint M_B_V   = 71427;

   localparam int OFS_Y = 16;
   localparam int OFS_C = 128;

   typedef struct packed {
      logic mul;
      logic sum;
   } stage_en_type;

   // round to nearest, halves up
   function automatic longint fx(input int frac_bits, input longint micro);
      return ((micro <<< frac_bits) + 64'sd500000) / 64'sd1000000;
   endfunction

endpackage

// File: hw/rtl/yfy_req_if.sv
// ----------------------------------------------------------------------------
// yfy_req_if
// Input pixel channel: valid/ready with luma and chroma pair.
// ----------------------------------------------------------------------------
interface yfy_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] luma_in;
   logic [7:0] cb_in;
   logic [7:0] cr_in;

   modport source (output valid, luma_in, cb_in, cr_in, input ready);
   modport sink   (input valid, luma_in, cb_in, cr_in, output ready);
endinterface

// File: hw/rtl/yfy_rsp_if.sv
// ----------------------------------------------------------------------------
// yfy_rsp_if
// Result pixel channel: valid/ready with recomputed luma and chroma.
// ----------------------------------------------------------------------------
interface yfy_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] luma_out;
   logic [7:0] cb_out;
   logic [7:0] cr_out;

   modport source (output valid, luma_out, cb_out, cr_out, input ready);
   modport sink   (input valid, luma_out, cb_out, cr_out, output ready);
endinterface

// File: hw/rtl/yfy_csr_if.sv
// ----------------------------------------------------------------------------
// yfy_csr_if
// Configuration write channel carrying the fade level.
// ----------------------------------------------------------------------------
interface yfy_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] fade_level;

   modport source (output valid, fade_level, input ready);
   modport sink   (input valid, fade_level, output ready);
endinterface

// File: hw/rtl/yuv_fade_yuv_pixel.sv
// Throughput: one transaction per cycle unless the response stalls; six
// register stages (two multiply/sum stages per color conversion, fade multiply,
// divide by 255) advance under per-stage ready, so bubbles collapse and a stall
// holds only the full stages between the output and the nearest bubble.
// Reset: synchronous, active high; clears stage valids, fade level to 255.
`include "yuv_fade_yuv_pixel_macros.svh"
// ----------------------------------------------------------------------------
// yuv_fade_yuv_pixel
// YCbCr to RGB, fade by fade_level/255, back to YCbCr; one pixel per unstalled clock.
// ----------------------------------------------------------------------------
module yuv_fade_yuv_pixel #(
   parameter int COEF_FRAC_BITS = yfy_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   yfy_req_if.sink       req_ch,
   yfy_rsp_if.source     rsp_ch,
   yfy_csr_if.sink       csr_ch
);
   import yfy_pkg::*;

   localparam int CW = COEF_FRAC_BITS + 3;

   localparam logic signed [CW-1:0] K_Y_RGB = CW'(fx(COEF_FRAC_BITS, M_Y_RGB));
   localparam logic signed [CW-1:0] K_V_R   = CW'(fx(COEF_FRAC_BITS, M_V_R));
   localparam logic signed [CW-1:0] K_U_G   = CW'(fx(COEF_FRAC_BITS, M_U_G));
   localparam logic signed [CW-1:0] K_V_G   = CW'(fx(COEF_FRAC_BITS, M_V_G));
   localparam logic signed [CW-1:0] K_U_B   = CW'(fx(COEF_FRAC_BITS, M_U_B));
   localparam logic signed [CW-1:0] K_R_Y   = CW'(fx(COEF_FRAC_BITS, M_R_Y));
   localparam logic signed [CW-1:0] K_G_Y   = CW'(fx(COEF_FRAC_BITS, M_G_Y));
   localparam logic signed [CW-1:0] K_B_Y   = CW'(fx(COEF_FRAC_BITS, M_B_Y));
   localparam logic signed [CW-1:0] K_R_U   = CW'(fx(COEF_FRAC_BITS, M_R_U));
   localparam logic signed [CW-1:0] K_G_U   = CW'(fx(COEF_FRAC_BITS, M_G_U));
   localparam logic signed [CW-1:0] K_B_U   = CW'(fx(COEF_FRAC_BITS, M_B_U));
   localparam logic signed [CW-1:0] K_R_V   = CW'(fx(COEF_FRAC_BITS, M_R_V));
   localparam logic signed [CW-1:0] K_G_V   = CW'(fx(COEF_FRAC_BITS, M_G_V));
   localparam logic signed [CW-1:0] K_B_V   = CW'(fx(COEF_FRAC_BITS, M_B_V));

   logic [STAGES-1:0] v_ff, v_in;
   logic [STAGES-1:0] rdy;
   logic [7:0]        fade_ff, fade_in;

   logic signed [8:0] y_s, u_s, v_s;
   logic [7:0]        r_c, g_c, b_c;
   logic [15:0]       rp_ff, gp_ff, bp_ff;
   logic [7:0]        rf_ff, gf_ff, bf_ff;
   logic [16:0]       rq, gq, bq;

   stage_en_type en_rgb, en_yuv;

   // ---------------------------------------------------------------- control
   always_comb begin
      rdy[STAGES-1] = !v_ff[STAGES-1] || rsp_ch.ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
      v_in[0] = rdy[0] ? req_ch.valid : v_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         v_in[i] = rdy[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   assign fade_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.fade_level : fade_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= '0;
         fade_ff <= FADE_RESET;
      end else begin
         v_ff    <= v_in;
         fade_ff <= fade_in;
      end
   end

   assign req_ch.ready = rdy[0];
   assign csr_ch.ready = 1'b1;

   assign en_rgb = '{mul: rdy[0], sum: rdy[1]};
   assign en_yuv = '{mul: rdy[4], sum: rdy[5]};

   // --------------------------------------------------------- YCbCr to RGB
   assign y_s = $signed({1'b0, req_ch.luma_in}) - 9'sd16;
   assign u_s = $signed({1'b0, req_ch.cb_in}) - 9'sd128;
   assign v_s = $signed({1'b0, req_ch.cr_in}) - 9'sd128;

   yfy_dot3 #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .C0(K_Y_RGB), .C1('0), .C2(K_V_R),
              .OFS(0)) u_r (
      .clock(clock), .en(en_rgb), .a(y_s), .b(u_s), .c(v_s), .res_ff(r_c));

   yfy_dot3 #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .C0(K_Y_RGB), .C1(-K_U_G), .C2(-K_V_G),
              .OFS(0)) u_g (
      .clock(clock), .en(en_rgb), .a(y_s), .b(u_s), .c(v_s), .res_ff(g_c));

   yfy_dot3 #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .C0(K_Y_RGB), .C1(K_U_B), .C2('0),
              .OFS(0)) u_b (
      .clock(clock), .en(en_rgb), .a(y_s), .b(u_s), .c(v_s), .res_ff(b_c));

   // ------------------------------------------------------------------ fade
   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         rp_ff <= 16'(r_c) * 16'(fade_ff);
         gp_ff <= 16'(g_c) * 16'(fade_ff);
         bp_ff <= 16'(b_c) * 16'(fade_ff);
      end
   end

   // divide by 255: (x + (x >> 8) + 1) >> 8, exact for x up to 255 * 255
   assign rq = 17'(rp_ff) + 17'(rp_ff[15:8]) + 17'd1;
   assign gq = 17'(gp_ff) + 17'(gp_ff[15:8]) + 17'd1;
   assign bq = 17'(bp_ff) + 17'(bp_ff[15:8]) + 17'd1;

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         rf_ff <= rq[15:8];
         gf_ff <= gq[15:8];
         bf_ff <= bq[15:8];
      end
   end

   // --------------------------------------------------------- RGB to YCbCr
   yfy_dot3 #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .C0(K_R_Y), .C1(K_G_Y), .C2(K_B_Y),
              .OFS(OFS_Y)) u_yo (
      .clock(clock), .en(en_yuv),
      .a($signed({1'b0, rf_ff})), .b($signed({1'b0, gf_ff})), .c($signed({1'b0, bf_ff})),
      .res_ff(rsp_ch.luma_out));

   yfy_dot3 #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .C0(-K_R_U), .C1(-K_G_U), .C2(K_B_U),
              .OFS(OFS_C)) u_uo (
      .clock(clock), .en(en_yuv),
      .a($signed({1'b0, rf_ff})), .b($signed({1'b0, gf_ff})), .c($signed({1'b0, bf_ff})),
      .res_ff(rsp_ch.cb_out));

   yfy_dot3 #(.COEF_FRAC_BITS(COEF_FRAC_BITS), .C0(K_R_V), .C1(-K_G_V), .C2(-K_B_V),
              .OFS(OFS_C)) u_vo (
      .clock(clock), .en(en_yuv),
      .a($signed({1'b0, rf_ff})), .b($signed({1'b0, gf_ff})), .c($signed({1'b0, bf_ff})),
      .res_ff(rsp_ch.cr_out));

   assign rsp_ch.valid = v_ff[STAGES-1];

   // ------------------------------------------------------------ assertions
   `YFY_ASSERT_IMPL(a_full_when_blocked, clock, reset, !req_ch.ready, &v_ff)
   `YFY_ASSERT_NEXT(a_accept_enters, clock, reset, req_ch.valid && req_ch.ready, v_ff[0])
   `YFY_ASSERT_NEXT(a_last_advance, clock, reset, v_ff[STAGES-2] && rdy[STAGES-1],
                    rsp_ch.valid)

endmodule

// File: hw/rtl/yfy_dot3.sv
// ----------------------------------------------------------------------------
// yfy_dot3
// Two-stage three-term fixed-point dot product with offset, truncation and
// clamp to 0..255.
// ----------------------------------------------------------------------------
module yfy_dot3 #(
   parameter int                            COEF_FRAC_BITS = yfy_pkg::COEF_FRAC_BITS_DEF,
   parameter logic signed [COEF_FRAC_BITS+2:0] C0          = '0,
   parameter logic signed [COEF_FRAC_BITS+2:0] C1          = '0,
   parameter logic signed [COEF_FRAC_BITS+2:0] C2          = '0,
   parameter int                            OFS            = 0
) (
   input  logic                 clock,
   input  yfy_pkg::stage_en_type en,
   input  logic signed [8:0]    a,
   input  logic signed [8:0]    b,
   input  logic signed [8:0]    c,
   output logic [7:0]           res_ff
);
   import yfy_pkg::*;

   localparam int CW = COEF_FRAC_BITS + 3;
   localparam int PW = CW + 9;
   localparam int SW = PW + 2;

   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff;
   logic signed [PW-1:0] p0_in, p1_in, p2_in;
   logic signed [SW-1:0] sum;
   logic signed [SW-1:0] shifted;
   logic [7:0]           res_in;

   assign p0_in = PW'(a) * PW'(C0);
   assign p1_in = PW'(b) * PW'(C1);
   assign p2_in = PW'(c) * PW'(C2);

   always_ff @(posedge clock) begin
      if (en.mul) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
   end

   // floor equals truncation here: any negative sum clamps to zero
   assign sum     = SW'(p0_ff) + SW'(p1_ff) + SW'(p2_ff)
                  + (SW'(OFS) <<< COEF_FRAC_BITS);
   assign shifted = sum >>> COEF_FRAC_BITS;

   always_comb begin
      priority if (shifted[SW-1]) begin
         res_in = 8'd0;
      end else if (|shifted[SW-2:8]) begin
         res_in = 8'd255;
      end else begin
         res_in = shifted[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.sum) begin
         res_ff <= res_in;
      end
   end

endmodule

// File: verif/yuv_fade_yuv_pixel_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_fade_yuv_pixel_tb
// Self-checking bench for the pixel fade pipeline. A table of directed pixels
// (black, clamped corners, primaries, zero and near-full fade) is followed by
// random phases, each with its own fade level and handshake pressure. Every
// response is compared with a tabled pixel or a bit-exact fixed-point model.
// ----------------------------------------------------------------------------
module yuv_fade_yuv_pixel_tb;

   localparam int     FRAC         = yfy_pkg::COEF_FRAC_BITS_DEF;
   localparam int     CLK_PERIOD   = 20;
   localparam int     RESET_CYCLES = 12;
   localparam int     DRAIN_CYCLES = 24;
   localparam int     PHASES       = 8;
   localparam int     PHASE_ITEMS  = 119;
   localparam int     DIRECTED_N   = 20;
   localparam longint CYCLE_LIMIT  = 400000;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] cb;
      logic [7:0] cr;
   } pixel_type;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] cb;
      logic [7:0] cr;
      logic [7:0] fade;
      logic       known;
      pixel_type  due;
   } stim_row_type;

   function automatic longint q_coef(input longint micro);
      longint scale;
      scale = longint'(1) << FRAC;
      return (micro * scale + 64'sd500000) / 64'sd1000000;
   endfunction

   localparam longint K_Y   = q_coef(1164383);
   localparam longint K_VR  = q_coef(1596027);
   localparam longint K_UG  = q_coef(391762);
   localparam longint K_VG  = q_coef(812968);
   localparam longint K_UB  = q_coef(2017232);
   localparam longint K_RY  = q_coef(256788);
   localparam longint K_GY  = q_coef(504129);
   localparam longint K_BY  = q_coef(97906);
   localparam longint K_RU  = q_coef(148223);
   localparam longint K_GU  = q_coef(290993);
   localparam longint K_BU  = q_coef(439216);
   localparam longint K_RV  = q_coef(439216);
   localparam longint K_GV  = q_coef(367788);
   localparam longint K_BV  = q_coef(71427);
   localparam longint ONE_Q = longint'(1) << FRAC;

   localparam pixel_type BLACK = '{8'd16, 8'd128, 8'd128};
   localparam pixel_type NONE  = '0;

   logic clock;
   logic reset;

   yfy_req_if req_ch ();
   yfy_rsp_if rsp_ch ();
   yfy_csr_if csr_ch ();

   pixel_type  faded_pixel_q[$];
   logic [7:0] fade_now;
   int         send_idle_pct;
   int         stall_pct;
   int         error_count = 0;
   longint     cycle_count = 0;

   stim_row_type directed_rows [DIRECTED_N] = '{
      '{8'd16,  8'd128, 8'd128, 8'd255, 1'b1, BLACK},
      '{8'd0,   8'd128, 8'd128, 8'd255, 1'b1, BLACK},
      '{8'd0,   8'd0,   8'd0,   8'd255, 1'b0, NONE},
      '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0, NONE},
      '{8'd255, 8'd0,   8'd0,   8'd255, 1'b0, NONE},
      '{8'd0,   8'd255, 8'd255, 8'd255, 1'b0, NONE},
      '{8'd235, 8'd128, 8'd128, 8'd255, 1'b0, NONE},
      '{8'd235, 8'd16,  8'd240, 8'd255, 1'b0, NONE},
      '{8'd81,  8'd90,  8'd240, 8'd255, 1'b0, NONE},
      '{8'd145, 8'd54,  8'd34,  8'd255, 1'b0, NONE},
      '{8'd41,  8'd240, 8'd110, 8'd255, 1'b0, NONE},
      '{8'd255, 8'd0,   8'd255, 8'd255, 1'b0, NONE},
      '{8'd0,   8'd255, 8'd0,   8'd255, 1'b0, NONE},
      '{8'd255, 8'd255, 8'd255, 8'd0,   1'b1, BLACK},
      '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, BLACK},
      '{8'd128, 8'd200, 8'd60,  8'd0,   1'b1, BLACK},
      '{8'd255, 8'd128, 8'd128, 8'd1,   1'b0, NONE},
      '{8'd235, 8'd0,   8'd255, 8'd1,   1'b0, NONE},
      '{8'd200, 8'd100, 8'd150, 8'd128, 1'b0, NONE},
      '{8'd255, 8'd255, 8'd0,   8'd254, 1'b0, NONE}
   };

   yuv_fade_yuv_pixel u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   function automatic longint descale(input longint acc);
      return acc / ONE_Q;
   endfunction

   function automatic logic [7:0] sat8(input longint v);
      if (v < 0) begin
         return 8'd0;
      end
      if (v > 255) begin
         return 8'd255;
      end
      return v[7:0];
   endfunction

   function automatic pixel_type fade_pixel(input pixel_type px, input logic [7:0] lvl);
      longint y, u, v, r, g, b;
      pixel_type res;
      y = longint'(px.luma) - 16;
      u = longint'(px.cb) - 128;
      v = longint'(px.cr) - 128;
      r = sat8(descale(K_Y * y + K_VR * v));
      g = sat8(descale(K_Y * y - K_UG * u - K_VG * v));
      b = sat8(descale(K_Y * y + K_UB * u));
      r = r * longint'(lvl) / 255;
      g = g * longint'(lvl) / 255;
      b = b * longint'(lvl) / 255;
      res.luma = sat8(descale(K_RY * r + K_GY * g + K_BY * b + 16 * ONE_Q));
      res.cb   = sat8(descale(-K_RU * r - K_GU * g + K_BU * b + 128 * ONE_Q));
      res.cr   = sat8(descale(K_RV * r - K_GV * g - K_BV * b + 128 * ONE_Q));
      return res;
   endfunction

   function automatic logic [7:0] pick_sample();
      if ($urandom_range(0, 99) < 75) begin
         return 8'($urandom_range(0, 255));
      end
      case ($urandom_range(0, 8))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd16;
         3: return 8'd127;
         4: return 8'd128;
         5: return 8'd235;
         6: return 8'd240;
         7: return 8'd254;
         default: return 8'd255;
      endcase
   endfunction

   task automatic send_pixel(input pixel_type px, input pixel_type due);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.luma_in <= px.luma;
      req_ch.cb_in   <= px.cb;
      req_ch.cr_in   <= px.cr;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      faded_pixel_q.push_back(due);
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (faded_pixel_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_fade(input logic [7:0] lvl);
      wait_for_results();
      csr_ch.valid      <= 1'b1;
      csr_ch.fade_level <= lvl;
      @(posedge clock);
      while (!csr_ch.ready) begin
         @(posedge clock);
      end
      csr_ch.valid <= 1'b0;
      fade_now = lvl;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("yuv_fade_yuv_pixel regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      pixel_type due;
      if (reset) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (faded_pixel_q.size() == 0) begin
               $error("unexpected transaction: luma_out %0d cb_out %0d cr_out %0d",
                      rsp_ch.luma_out, rsp_ch.cb_out, rsp_ch.cr_out);
               error_count++;
            end else begin
               due = faded_pixel_q.pop_front();
               if (rsp_ch.luma_out !== due.luma) begin
                  $error("luma_out expected %0d actual %0d", due.luma, rsp_ch.luma_out);
                  error_count++;
               end
               if (rsp_ch.cb_out !== due.cb) begin
                  $error("cb_out expected %0d actual %0d", due.cb, rsp_ch.cb_out);
                  error_count++;
               end
               if (rsp_ch.cr_out !== due.cr) begin
                  $error("cr_out expected %0d actual %0d", due.cr, rsp_ch.cr_out);
                  error_count++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      pixel_type     px;
      logic [7:0]    lvl;
      idle_mode_type mode;
      send_idle_pct     = 0;
      stall_pct         = 0;
      fade_now          = yfy_pkg::FADE_RESET;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.luma_in    <= '0;
      req_ch.cb_in      <= '0;
      req_ch.cr_in      <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.fade_level <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_N; r++) begin
         if (directed_rows[r].fade != fade_now) begin
            set_fade(directed_rows[r].fade);
         end
         px = '{directed_rows[r].luma, directed_rows[r].cb, directed_rows[r].cr};
         send_pixel(px, directed_rows[r].known ? directed_rows[r].due
                                               : fade_pixel(px, fade_now));
      end

      for (int p = 0; p < PHASES; p++) begin
         mode = idle_mode_type'(p % 4);
         case (p)
            0: lvl = 8'd255;
            1: lvl = 8'd0;
            3: lvl = 8'd1;
            4: lvl = 8'd128;
            6: lvl = 8'd254;
            default: lvl = 8'($urandom_range(2, 253));
         endcase
         set_fade(lvl);
         case (mode)
            IDLE_NONE: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            IDLE_SENDER: begin
               send_idle_pct = 68;
               stall_pct     = 0;
            end
            IDLE_RECEIVER: begin
               send_idle_pct = 0;
               stall_pct     = 68;
            end
            default: begin
               send_idle_pct = 9;
               stall_pct     = 9;
            end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 1 && i == PHASE_ITEMS / 2) begin
               wait_for_results();
            end
            px.luma = pick_sample();
            px.cb   = pick_sample();
            px.cr   = pick_sample();
            send_pixel(px, fade_pixel(px, fade_now));
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("yuv_fade_yuv_pixel regression: pass");
      end else begin
         $display("yuv_fade_yuv_pixel regression: fail");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/yfy_pkg.sv
hw/rtl/yfy_req_if.sv
hw/rtl/yfy_rsp_if.sv
hw/rtl/yfy_csr_if.sv
hw/rtl/yfy_dot3.sv
hw/rtl/yuv_fade_yuv_pixel.sv
verif/yuv_fade_yuv_pixel_tb.sv
